[rtl/core/sdr_pkg.sv]
// shared types and constants for the signed divider register block
// used by sdr_dp, sdr_ctrl and signed_divider_regs_top; no dependencies
`timescale 1ns / 1ps

package sdr_pkg;

    localparam int WORD_W   = 32;
    localparam int DATA_W   = 64;
    localparam int MODE_W   = 2;
    localparam int OP_W     = 3;
    localparam int CNT_W    = $clog2(DATA_W);
    localparam int IN_W     = 2 * WORD_W;
    localparam int RES_W    = 2 * DATA_W + 1 + MODE_W;
    localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] SIGN64     = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] UPPER_MASK = {{WORD_W{1'b1}}, {WORD_W{1'b0}}};
    localparam logic [DATA_W-1:0] MIN32_SEXT = {{(WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] ALL_ONES   = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] ONE64      = {{(DATA_W-1){1'b0}}, 1'b1};
    localparam logic [CNT_W-1:0]  LAST_STEP  = {CNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_MODE    = 3'd0,
        OP_NUM_LO  = 3'd1,
        OP_NUM_HI  = 3'd2,
        OP_DEN_LO  = 3'd3,
        OP_DEN_HI  = 3'd4
    } t_opcode;

    typedef enum logic [MODE_W-1:0] {
        MODE_32    = 2'd0,
        MODE_64_32 = 2'd1,
        MODE_64_64 = 2'd2,
        MODE_64_32B = 2'd3
    } t_mode;

    // controller to datapath
    typedef struct packed {
        logic write;
        logic setup;
        logic iter;
        logic fix;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic recalc;
        logic special;
        logic last;
    } t_sts;

endpackage

[rtl/core/signed_divider_regs_top.sv]
// top level of the register-mapped signed divider
// depends on sdr_pkg, sdr_ctrl and sdr_dp
`timescale 1ns / 1ps

// Each request is one masked write to the mode, numerator or denominator word; opcodes
// above the denominator high word write nothing. After a write the 64-bit quotient and
// remainder are recomputed and one result is returned carrying quotient, remainder,
// the zero-denominator flag and the mode. A full division passes through a setup step,
// 64 steps of the one-bit-per-cycle restoring divide loop, a sign fix step and the load
// of the result register. Division by zero and the minimum-by-minus-one overflow skip
// the loop and the sign fix and go from setup straight to the result load, as an unused
// opcode does. One request is in flight at a time; the next is taken once the previous
// result has reached the output register, even if it has not been taken yet.
module signed_divider_regs_top
    import sdr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_W-1:0]     s_axis_tdata,   // write_mask[31:0], write_data[63:32]
    input  logic [OP_W-1:0]     s_axis_tuser,   // opcode[2:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata    // quotient[63:0], remainder[127:64],
                                                // div_by_zero[128], mode_out[130:129]
);

    t_cmd cmd;
    t_sts sts;

    sdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sdr_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_opcode (s_axis_tuser),
        .i_mask   (s_axis_tdata[WORD_W-1:0]),
        .i_data   (s_axis_tdata[IN_W-1:WORD_W]),
        .o_result (m_axis_tdata)
    );

endmodule

[rtl/core/sdr_dp.sv]
// datapath: operand registers, special-case decode and radix-2 restoring divider
// depends on sdr_pkg; driven by sdr_ctrl commands
`timescale 1ns / 1ps

module sdr_dp
    import sdr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [WORD_W-1:0]   i_mask,
    input  logic [WORD_W-1:0]   i_data,
    output logic [OUT_W-1:0]    o_result
);

    logic [MODE_W-1:0]  r_mode;
    logic [DATA_W-1:0]  r_num;
    logic [DATA_W-1:0]  r_den;
    logic [DATA_W-1:0]  r_quot;
    logic [DATA_W-1:0]  r_rem;
    logic               r_zero;
    logic               r_recalc;

    logic [DATA_W-1:0]  r_acc;
    logic [DATA_W-1:0]  r_quo;
    logic [DATA_W-1:0]  r_dvs;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_qneg;
    logic               r_rneg;
    logic [OUT_W-1:0]   r_out;

    logic [DATA_W-1:0]  n_val;
    logic [DATA_W-1:0]  d_val;
    logic               n_neg;
    logic               d_neg;
    logic               sp_ovf;
    logic               sp_zero;
    logic [DATA_W-1:0]  sp_quot;
    logic [DATA_W-1:0]  sp_rem;
    logic [DATA_W:0]    trial;
    logic               op_ok;

    always_comb begin
        case (t_opcode'(i_opcode))
            OP_MODE, OP_NUM_LO, OP_NUM_HI, OP_DEN_LO, OP_DEN_HI: op_ok = 1'b1;
            default: op_ok = 1'b0;
        endcase
    end

    // operands as the current mode sees them
    always_comb begin
        if (t_mode'(r_mode) == MODE_32) begin
            n_val = {{WORD_W{r_num[WORD_W-1]}}, r_num[WORD_W-1:0]};
            d_val = {{WORD_W{r_den[WORD_W-1]}}, r_den[WORD_W-1:0]};
        end else if (t_mode'(r_mode) == MODE_64_64) begin
            n_val = r_num;
            d_val = r_den;
        end else begin
            n_val = r_num;
            d_val = {{WORD_W{r_den[WORD_W-1]}}, r_den[WORD_W-1:0]};
        end
        n_neg = n_val[DATA_W-1];
        d_neg = d_val[DATA_W-1];
    end

    always_comb begin
        if (t_mode'(r_mode) == MODE_32) begin
            sp_ovf  = (n_val == MIN32_SEXT) && (d_val == ALL_ONES);
            sp_quot = sp_ovf ? (n_val ^ UPPER_MASK)
                             : ((n_neg ? ONE64 : ALL_ONES) ^ UPPER_MASK);
        end else begin
            sp_ovf  = (n_val == SIGN64) && (d_val == ALL_ONES);
            sp_quot = sp_ovf ? n_val : (n_neg ? ONE64 : ALL_ONES);
        end
        sp_zero = (d_val == '0);
        sp_rem  = sp_ovf ? '0 : n_val;
    end

    assign trial = {r_acc, r_quo[DATA_W-1]} - {1'b0, r_dvs};

    // architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_num    <= '0;
            r_den    <= '0;
            r_quot   <= '0;
            r_rem    <= '0;
            r_zero   <= 1'b0;
            r_recalc <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_recalc <= op_ok;
                case (t_opcode'(i_opcode))
                    OP_MODE:   r_mode <= (r_mode & ~i_mask[MODE_W-1:0])
                                       | (i_data[MODE_W-1:0] & i_mask[MODE_W-1:0]);
                    OP_NUM_LO: r_num[WORD_W-1:0] <= (r_num[WORD_W-1:0] & ~i_mask)
                                                  | (i_data & i_mask);
                    OP_NUM_HI: r_num[DATA_W-1:WORD_W] <= (r_num[DATA_W-1:WORD_W] & ~i_mask)
                                                       | (i_data & i_mask);
                    OP_DEN_LO: r_den[WORD_W-1:0] <= (r_den[WORD_W-1:0] & ~i_mask)
                                                  | (i_data & i_mask);
                    OP_DEN_HI: r_den[DATA_W-1:WORD_W] <= (r_den[DATA_W-1:WORD_W] & ~i_mask)
                                                       | (i_data & i_mask);
                    default: ;
                endcase
            end
            if (i_cmd.setup && r_recalc) begin
                r_zero <= (r_den == '0);
                if (sp_ovf || sp_zero) begin
                    r_quot <= sp_quot;
                    r_rem  <= sp_rem;
                end
            end
            if (i_cmd.fix) begin
                r_quot <= r_qneg ? (DATA_W'(0) - r_quo) : r_quo;
                r_rem  <= r_rneg ? (DATA_W'(0) - r_acc) : r_acc;
            end
        end
    end

    // divider working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_acc  <= '0;
            r_quo  <= n_neg ? (DATA_W'(0) - n_val) : n_val;
            r_dvs  <= d_neg ? (DATA_W'(0) - d_val) : d_val;
            r_qneg <= n_neg ^ d_neg;
            r_rneg <= n_neg;
        end else if (i_cmd.iter) begin
            if (!trial[DATA_W]) begin
                r_acc <= trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_acc <= {r_acc[DATA_W-2:0], r_quo[DATA_W-1]};
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.setup) begin
            r_cnt <= '0;
        end else if (i_cmd.iter) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= {{(OUT_W-RES_W){1'b0}}, r_mode, r_zero, r_rem, r_quot};
        end
    end

    assign o_sts.recalc  = r_recalc;
    assign o_sts.special = sp_ovf || sp_zero;
    assign o_sts.last    = (r_cnt == LAST_STEP);
    assign o_result      = r_out;

endmodule

[rtl/core/sdr_ctrl.sv]
// controller: sequences register write, setup, divide steps, sign fix and result load
// depends on sdr_pkg; commands sdr_dp
`timescale 1ns / 1ps

module sdr_ctrl
    import sdr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_sts    i_sts
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_ITER  = 5'b00100,
        S_FIX   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   load;

    assign accept = (r_state == S_IDLE) && i_in_valid;
    // result register is free when empty or being drained
    assign load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SETUP;
            S_SETUP: begin
                if (!i_sts.recalc || i_sts.special) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ITER;
                end
            end
            S_ITER:  if (i_sts.last) n_state = S_FIX;
            S_FIX:   n_state = S_DONE;
            S_DONE:  if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.write = accept;
    assign o_cmd.setup = (r_state == S_SETUP);
    assign o_cmd.iter  = (r_state == S_ITER);
    assign o_cmd.fix   = (r_state == S_FIX);
    assign o_cmd.load  = load;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SETUP))
        else $error("request not followed by setup");

    a_last_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER) && i_sts.last |=> (r_state == S_FIX))
        else $error("divide loop did not end after final step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !load)
        else $error("pending result overwritten");

    a_fix_from_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> $past(r_state) == S_ITER)
        else $error("sign fix entered without divide loop");

endmodule

[sim/tb.sv]
// testbench for signed_divider_regs_top: directed register writes, then random operand sets
// checks every result against an in-bench divider model or a hand-worked value; depends on sdr_pkg and the rtl
`timescale 1ns / 1ps

module tb;
    import sdr_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_DEN_HI + 1'b1;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = {OP_W{1'b1}};
    localparam int RANDOM_WRITES = 525;
    localparam int CALM_WRITES   = 60;
    localparam int HOLD_AT       = 80;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 80;

    typedef struct packed {
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
        logic              dbz;
        logic [MODE_W-1:0] mode;
    } t_div_result;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] data;
        logic              known;
        t_div_result       want;
    } t_write_row;

    localparam int N_ROWS = 24;
    // rows marked known carry a hand-worked result, the rest go through the model
    localparam t_write_row WRITE_PLAN [N_ROWS] = '{
        '{OP_UNUSED_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{64'h0, 64'h0, 1'b0, MODE_32}},
        '{OP_NUM_LO, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
          '{64'hFFFF_FFFF_0000_0001, 64'hFFFF_FFFF_8000_0000, 1'b1, MODE_32}},
        '{OP_DEN_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{64'h0000_0000_8000_0000, 64'h0, 1'b0, MODE_32}},
        '{OP_MODE, 32'h0000_0003, 32'(MODE_64_32), 1'b1,
          '{64'hFFFF_FFFF_8000_0000, 64'h0, 1'b0, MODE_64_32}},
        '{OP_NUM_HI, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0},
        '{OP_NUM_LO, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{64'h8000_0000_0000_0000, 64'h0, 1'b0, MODE_64_32}},
        '{OP_MODE, 32'h0000_0003, 32'(MODE_64_64), 1'b0, '0},
        '{OP_DEN_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{64'h8000_0000_0000_0000, 64'h0, 1'b0, MODE_64_64}},
        '{OP_MODE, 32'h0000_0003, 32'(MODE_64_32B), 1'b1,
          '{64'h8000_0000_0000_0000, 64'h0, 1'b0, MODE_64_32B}},
        // low divisor word zero but full denominator non-zero
        '{OP_DEN_LO, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{64'h1, 64'h8000_0000_0000_0000, 1'b0, MODE_64_32B}},
        '{OP_MODE, 32'h0000_0003, 32'(MODE_64_32), 1'b0, '0},
        '{OP_MODE, 32'h0000_0003, 32'(MODE_64_64), 1'b0, '0},
        '{OP_DEN_HI, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{64'h1, 64'h8000_0000_0000_0000, 1'b1, MODE_64_64}},
        '{OP_NUM_HI, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, MODE_64_64}},
        '{OP_MODE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_MODE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_MODE, 32'h0000_0003, 32'hFFFF_FFFC, 1'b1,
          '{64'h0000_0000_FFFF_FFFF, 64'h0, 1'b1, MODE_32}},
        '{OP_NUM_LO, 32'h0000_FFFF, 32'h1234_5678, 1'b0, '0},
        '{OP_DEN_LO, 32'hFF00_FF00, 32'hAAAA_55AA, 1'b0, '0},
        '{OP_UNUSED_FIRST, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{OP_NUM_HI, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
        '{OP_MODE, 32'h0000_0003, 32'(MODE_64_64), 1'b0, '0},
        '{OP_NUM_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_DEN_LO, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;   // write_mask[31:0], write_data[63:32]
    logic [OP_W-1:0]    s_axis_tuser;   // opcode[2:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;   // quotient[63:0], remainder[127:64],
                                        // div_by_zero[128], mode_out[130:129]

    signed_divider_regs_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // divider model state
    t_mode             mdl_mode;
    logic [DATA_W-1:0] mdl_num;
    logic [DATA_W-1:0] mdl_den;
    logic [DATA_W-1:0] mdl_quo;
    logic [DATA_W-1:0] mdl_rem;
    logic              mdl_zero;

    t_div_result pending_results[$];
    int          n_requests;
    int          n_writes;
    int          n_checked;
    int          n_errors;
    bit          calm;
    t_div_result got_res;
    t_div_result want_res;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // applies one masked write and recomputes the quotient and remainder registers
    function automatic t_div_result apply_write(input logic [OP_W-1:0] op,
                                                input logic [WORD_W-1:0] mask,
                                                input logic [WORD_W-1:0] data);
        logic              wrote;
        logic [MODE_W-1:0] mm;
        logic [DATA_W-1:0] n, d, lim, flip, an, ad, uq, ur;
        logic              nneg, dneg;
        t_div_result       res;
        wrote = 1'b1;
        case (op)
            OP_MODE: begin
                mm = mask[MODE_W-1:0];
                mdl_mode = t_mode'((mdl_mode & ~mm) | (data[MODE_W-1:0] & mm));
            end
            OP_NUM_LO: mdl_num[WORD_W-1:0] = (mdl_num[WORD_W-1:0] & ~mask) | (data & mask);
            OP_NUM_HI: mdl_num[DATA_W-1:WORD_W] =
                (mdl_num[DATA_W-1:WORD_W] & ~mask) | (data & mask);
            OP_DEN_LO: mdl_den[WORD_W-1:0] = (mdl_den[WORD_W-1:0] & ~mask) | (data & mask);
            OP_DEN_HI: mdl_den[DATA_W-1:WORD_W] =
                (mdl_den[DATA_W-1:WORD_W] & ~mask) | (data & mask);
            default: wrote = 1'b0;
        endcase
        if (wrote) begin
            mdl_zero = (mdl_den == '0);
            if (mdl_mode == MODE_32) begin
                n    = {{WORD_W{mdl_num[WORD_W-1]}}, mdl_num[WORD_W-1:0]};
                d    = {{WORD_W{mdl_den[WORD_W-1]}}, mdl_den[WORD_W-1:0]};
                lim  = MIN32_SEXT;
                flip = UPPER_MASK;
            end else begin
                n    = mdl_num;
                d    = (mdl_mode == MODE_64_64) ? mdl_den :
                       {{WORD_W{mdl_den[WORD_W-1]}}, mdl_den[WORD_W-1:0]};
                lim  = SIGN64;
                flip = '0;
            end
            if (n == lim && d == ALL_ONES) begin
                mdl_quo = n ^ flip;
                mdl_rem = '0;
            end else if (d != '0) begin
                nneg = n[DATA_W-1];
                dneg = d[DATA_W-1];
                an = nneg ? (64'd0 - n) : n;
                ad = dneg ? (64'd0 - d) : d;
                uq = an / ad;
                ur = an % ad;
                mdl_quo = (nneg != dneg) ? (64'd0 - uq) : uq;
                mdl_rem = nneg ? (64'd0 - ur) : ur;
            end else begin
                mdl_quo = (n[DATA_W-1] ? ONE64 : ALL_ONES) ^ flip;
                mdl_rem = n;
            end
        end
        res.quo  = mdl_quo;
        res.rem  = mdl_rem;
        res.dbz  = mdl_zero;
        res.mode = mdl_mode;
        return res;
    endfunction

    // operand words biased towards the corners of the signed range
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'($urandom_range(0, 15));
            6: return 32'h0 - 32'($urandom_range(1, 16));
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch: %s at result %0d: got %h expected %h", what, n_checked, got, want);
        n_errors++;
    endtask

    // entered and left at a falling edge
    task automatic send_request(input t_write_row row);
        int          gap;
        t_div_result predicted;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = row.op;
        s_axis_tdata  = {row.data, row.mask};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = apply_write(row.op, row.mask, row.data);
        pending_results.push_back(row.known ? row.want : predicted);
        n_requests++;
        if (row.op <= OP_DEN_HI) n_writes++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res.quo  = m_axis_tdata[DATA_W-1:0];
            got_res.rem  = m_axis_tdata[2*DATA_W-1:DATA_W];
            got_res.dbz  = m_axis_tdata[2*DATA_W];
            got_res.mode = m_axis_tdata[2*DATA_W+MODE_W:2*DATA_W+1];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", got_res.quo, '0);
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.quo !== want_res.quo)
                    report_mismatch("quotient", got_res.quo, want_res.quo);
                if (got_res.rem !== want_res.rem)
                    report_mismatch("remainder", got_res.rem, want_res.rem);
                if (got_res.dbz !== want_res.dbz)
                    report_mismatch("div_by_zero", 64'(got_res.dbz), 64'(want_res.dbz));
                if (got_res.mode !== want_res.mode)
                    report_mismatch("mode", 64'(got_res.mode), 64'(want_res.mode));
            end
            n_checked++;
        end
    end

    // result side: random stall bursts, one long hold-off so the input backs up
    initial begin
        int  rdy_rate;
        int  gap;
        bit  held;
        m_axis_tready = 1'b0;
        rdy_rate = 1;
        held = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 99) == 0) rdy_rate = $urandom_range(0, 3);
            if (!held && n_requests >= HOLD_AT) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held = 1'b1;
            end else if (!calm && rdy_rate != 0 && $urandom_range(0, (2 << rdy_rate)) == 0)
            begin
                m_axis_tready = 1'b0;
                gap = $urandom_range(1, 18);
                repeat (gap) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    initial begin
        t_write_row        row;
        int                rand_writes;
        logic [WORD_W-1:0] lo;
        bit                ovf;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        calm          = 1'b0;
        n_requests    = 0;
        n_writes      = 0;
        n_checked     = 0;
        n_errors      = 0;
        mdl_mode      = MODE_32;
        mdl_num       = '0;
        mdl_den       = '0;
        mdl_quo       = '0;
        mdl_rem       = '0;
        mdl_zero      = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_ROWS; i++) send_request(WRITE_PLAN[i]);

        rand_writes = 0;
        row.known = 1'b0;
        row.want  = '0;
        while (rand_writes < RANDOM_WRITES) begin
            calm = (rand_writes >= RANDOM_WRITES - CALM_WRITES);
            if ($urandom_range(0, 9) < 7) begin
                // full operand set: mode, numerator, denominator
                ovf = ($urandom_range(0, 7) == 0);
                row.op = OP_MODE;
                row.mask = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0000_0003;
                row.data = $urandom;
                send_request(row);
                row.mask = 32'hFFFF_FFFF;
                lo = ovf ? ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0) : pick_word();
                row.op = OP_NUM_LO;
                row.data = lo;
                send_request(row);
                row.op = OP_NUM_HI;
                if (ovf)
                    row.data = (lo == 32'h0) ? 32'h8000_0000 : 32'hFFFF_FFFF;
                else
                    row.data = $urandom_range(0, 1) ? pick_word() : {WORD_W{lo[WORD_W-1]}};
                send_request(row);
                lo = ovf ? 32'hFFFF_FFFF : pick_word();
                row.op = OP_DEN_LO;
                row.data = lo;
                send_request(row);
                row.op = OP_DEN_HI;
                row.data = (ovf || $urandom_range(0, 1)) ? {WORD_W{lo[WORD_W-1]}} : pick_word();
                send_request(row);
                rand_writes += 5;
            end else begin
                row.op   = OP_W'($urandom_range(0, 7));
                row.mask = $urandom;
                row.data = $urandom;
                send_request(row);
                if (row.op <= OP_DEN_HI) rand_writes++;
            end
        end
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d requests (%0d register writes) over all modes and special cases",
                 n_requests, n_writes);
        $display("checked %0d results, %0d field errors", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
